// ===== rtl/dvr_pkg.sv =====
// distance vector router: shared types and codes
// used by dvr_ctrl, dvr_datapath and distance_vector_router
package dvr_pkg;

  typedef enum logic [1:0] {
    OP_SET_LINK   = 2'd0,
    OP_VECTOR     = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SELF_ID        = 2'd0,
    REG_NODE_COUNT     = 2'd1,
    REG_NEIGHBOR_COUNT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic dc_own;
    logic rc_init;
    logic rd_issue;
    logic rc_write;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic last;
    logic skip_d;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/dvr_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module dvr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dvr_ctrl.sv =====
// distance vector router: controller state machine and walk counters
// depends on dvr_pkg
module dvr_ctrl
  import dvr_pkg::*;
#(
  parameter int NODES     = 16,
  parameter int NEIGHBORS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [$clog2(NODES+1)-1:0]                    nc,
  input  logic [$clog2(NEIGHBORS+1)-1:0]                ns,
  input  status_t                                       st,
  output cmd_t                                          cmd,
  output logic [$clog2(NODES)-1:0]                      d,
  output logic [((NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1)-1:0] j
);

  localparam int NIW = $clog2(NODES);
  localparam int SIW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int NCW = $clog2(NODES + 1);
  localparam int NSW = $clog2(NEIGHBORS + 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_EXEC     = 8'b00000010,
    S_DC_OWN   = 8'b00000100,
    S_RC_INIT  = 8'b00001000,
    S_RC_RUN   = 8'b00010000,
    S_RC_DRAIN = 8'b00100000,
    S_RC_WRITE = 8'b01000000,
    S_FIN      = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [NIW-1:0] d_next;
  logic [SIW-1:0] j_next;
  logic d_last, j_last, nc_zero;

  assign d_last  = (NCW'(d) + NCW'(1)) == nc;
  assign j_last  = (NSW'(j) + NSW'(1)) == ns;
  assign nc_zero = nc == '0;
  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    d_next     = d;
    j_next     = j;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        d_next   = '0;
        unique case (st.op)
          OP_VECTOR: begin
            state_next = (st.hit && st.last && !nc_zero) ? S_RC_INIT : S_FIN;
          end
          OP_DISCONNECT: begin
            state_next = nc_zero ? S_FIN : S_DC_OWN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_DC_OWN: begin
        cmd.dc_own = 1'b1;
        if (d_last) begin
          d_next     = '0;
          state_next = S_RC_INIT;
        end else begin
          d_next = d + NIW'(1);
        end
      end
      S_RC_INIT: begin
        cmd.rc_init = 1'b1;
        j_next      = '0;
        state_next  = (st.skip_d || ns == '0) ? S_RC_WRITE : S_RC_RUN;
      end
      S_RC_RUN: begin
        cmd.rd_issue = 1'b1;
        if (j_last) begin
          state_next = S_RC_DRAIN;
        end else begin
          j_next = j + SIW'(1);
        end
      end
      S_RC_DRAIN: begin
        state_next = S_RC_WRITE;
      end
      S_RC_WRITE: begin
        cmd.rc_write = 1'b1;
        if (d_last) begin
          state_next = S_FIN;
        end else begin
          d_next     = d + NIW'(1);
          state_next = S_RC_INIT;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      d     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      d     <= d_next;
      j     <= j_next;
    end
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RC_RUN |-> (NSW'(j) < ns))
    else $error("slot walk past active slots");

  a_run_not_skipped: assert property (@(posedge clk) disable iff (rst)
    state == S_RC_RUN |-> !st.skip_d)
    else $error("walk on a skipped destination");

  a_fin_release: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !st.out_busy |=> state == S_IDLE)
    else $error("result not released");

  a_idle_one_request: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_EXEC)
    else $error("request not executed");

endmodule

// ===== rtl/dvr_datapath.sv =====
// distance vector router: tables, vector ram, compare unit and result register
// depends on dvr_pkg and dvr_ram
module dvr_datapath
  import dvr_pkg::*;
#(
  parameter int NODES     = 16,
  parameter int NEIGHBORS = 8,
  parameter int INFINITE  = 999
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [1:0]                                    s_command,
  input  logic [2:0]                                    s_slot,
  input  logic [3:0]                                    s_source,
  input  logic [3:0]                                    s_target,
  input  logic [9:0]                                    s_cost,
  input  logic                                          s_last,
  input  logic [3:0]                                    self_id,
  input  logic [$clog2(NODES+1)-1:0]                    nc,
  input  logic [$clog2(NEIGHBORS+1)-1:0]                ns,
  input  cmd_t                                          cmd,
  input  logic [$clog2(NODES)-1:0]                      d,
  input  logic [((NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1)-1:0] j,
  output status_t                                       st,
  input  logic                                          m_tready,
  output logic                                          m_tvalid,
  output logic                                          m_status,
  output logic [3:0]                                    m_next_hop,
  output logic                                          m_found
);

  localparam int NIW    = $clog2(NODES);
  localparam int SIW    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int CW     = $clog2(INFINITE + 1);
  localparam int AW     = SIW + NIW;
  localparam int VDEPTH = 2 ** AW;
  localparam logic [CW-1:0] INF = CW'(INFINITE);

  op_t            op_r;
  logic [2:0]     slot_r;
  logic [3:0]     src_r, tgt_r;
  logic [CW-1:0]  cost_r;
  logic           last_r;

  logic [3:0]     nn   [NEIGHBORS];
  logic [CW-1:0]  link [NEIGHBORS];
  logic [CW-1:0]  own  [NODES];
  logic [3:0]     hop  [NODES];
  logic           hv   [NODES];
  logic           vv   [VDEPTH];

  logic           hit;
  logic [SIW-1:0] hit_j;
  logic           tgt_ok, ram_we;
  logic [AW-1:0]  waddr, raddr;
  logic [CW-1:0]  ram_q;
  logic           vv_q, cmp_en;
  logic [SIW-1:0] p_j;
  logic [3:0]     nnp;
  logic [NIW-1:0] own_addr;
  logic [CW-1:0]  own_rd, first, vcost, sumc, dc_val;
  logic [CW:0]    sum;
  logic [CW-1:0]  best;
  logic [3:0]     best_hop;
  logic           improved, every_finite, route_ok;
  logic           res_status, res_found;
  logic [3:0]     res_hop;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(s_command);
      slot_r <= s_slot;
      src_r  <= s_source;
      tgt_r  <= s_target;
      cost_r <= (32'(s_cost) > INFINITE) ? INF : CW'(s_cost);
      last_r <= s_last;
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int k = NEIGHBORS - 1; k >= 0; k--) begin
      if (k < int'(ns) && nn[k] == src_r) begin
        hit   = 1'b1;
        hit_j = SIW'(k);
      end
    end
  end

  assign tgt_ok       = int'(tgt_r) < int'(nc);
  assign ram_we       = cmd.exec && op_r == OP_VECTOR && hit && tgt_ok;
  assign waddr        = {hit_j, NIW'(tgt_r)};
  assign raddr        = {j, d};
  assign every_finite = op_r == OP_DISCONNECT;

  assign st.op       = op_r;
  assign st.hit      = hit;
  assign st.last     = last_r;
  assign st.skip_d   = (int'(d) == int'(self_id)) ||
                       (op_r == OP_DISCONNECT && int'(d) == int'(src_r));
  assign st.out_busy = m_tvalid && !m_tready;

  dvr_ram #(.WIDTH(CW), .DEPTH(VDEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (cost_r),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_issue;
    end
    vv_q <= vv[raddr];
    p_j  <= j;
  end

  assign nnp      = nn[p_j];
  assign own_addr = cmd.rc_init ? d : NIW'(nnp);
  assign own_rd   = own[own_addr];
  assign first    = (int'(nnp) < int'(nc)) ? own_rd : INF;
  assign vcost    = vv_q ? ram_q : INF;
  assign sum      = {1'b0, first} + {1'b0, vcost};
  assign sumc     = (sum > {1'b0, INF}) ? INF : sum[CW-1:0];

  always_comb begin
    dc_val = (int'(d) == int'(self_id)) ? '0 : INF;
    for (int k = 0; k < NEIGHBORS; k++) begin
      if (k < int'(ns) && int'(nn[k]) == int'(d)) begin
        dc_val = link[k];
      end
    end
    if (self_id == src_r || int'(d) == int'(src_r)) begin
      dc_val = INF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rc_init) begin
      best     <= own_rd;
      best_hop <= 4'(d);
      improved <= 1'b0;
    end else if (cmp_en && sumc < best) begin
      best     <= sumc;
      best_hop <= nnp;
      improved <= 1'b1;
    end
  end

  assign route_ok = every_finite ? (best != INF) : improved;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NEIGHBORS; k++) begin
        nn[k]   <= '0;
        link[k] <= INF;
      end
      for (int n = 0; n < NODES; n++) begin
        own[n] <= INF;
        hv[n]  <= 1'b0;
      end
      for (int a = 0; a < VDEPTH; a++) begin
        vv[a] <= 1'b0;
      end
    end else begin
      if (cmd.exec && op_r == OP_SET_LINK && 32'(slot_r) < NEIGHBORS) begin
        nn[SIW'(slot_r)]   <= src_r;
        link[SIW'(slot_r)] <= cost_r;
      end
      if (ram_we) begin
        vv[waddr] <= 1'b1;
      end
      if (cmd.exec && op_r == OP_DISCONNECT) begin
        for (int k = 0; k < NEIGHBORS; k++) begin
          if (k < int'(ns) && nn[k] == src_r) begin
            link[k] <= INF;
          end
          for (int n = 0; n < NODES; n++) begin
            if (k < int'(ns) && n < int'(nc) && (nn[k] == src_r || n == int'(src_r))) begin
              vv[{SIW'(k), NIW'(n)}] <= 1'b0;
            end
          end
        end
        if (int'(src_r) < NODES) begin
          hv[NIW'(src_r)] <= 1'b0;
        end
      end
      if (cmd.dc_own) begin
        own[d] <= dc_val;
      end
      if (cmd.rc_write) begin
        own[d] <= best;
        if (route_ok) begin
          hv[d] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rc_write && route_ok) begin
      hop[d] <= best_hop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= op_r == OP_VECTOR && !hit;
      res_found  <= 1'b0;
      res_hop    <= '0;
      if (op_r == OP_LOOKUP && int'(tgt_r) < NODES && hv[NIW'(tgt_r)]) begin
        res_found <= 1'b1;
        res_hop   <= hop[NIW'(tgt_r)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.load_out) begin
      m_status   <= res_status;
      m_next_hop <= res_hop;
      m_found    <= res_found;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("result lost");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_tvalid && !m_tready))
    else $error("result overwritten");

  a_cmp_after_issue: assert property (@(posedge clk) disable iff (rst)
    cmp_en |-> $past(cmd.rd_issue))
    else $error("compare without read");

endmodule

// ===== rtl/distance_vector_router.sv =====
// distance vector router top level: stream ports, register port, effective counts
// depends on dvr_pkg, dvr_ctrl, dvr_datapath, dvr_ram
//
// one request in on the s_ channel, exactly one result out on the m_ channel.
// commands: set_link, vector_entry, disconnect, lookup (s_tuser).
// set_link, lookup and vector entries without last go from the execute state
// straight to the finish state that loads the result. a last vector entry from
// an active neighbor recomputes the own vector over nc nodes and ns active
// slots, one cost pair a cycle through the single read port of the neighbor
// vector ram; disconnect first rebuilds the own vector node by node, then recomputes.
// one request is worked at a time; a new one is taken as soon as the
// previous result sits in the output register.
// a stalled receiver holds the result; the next request still runs but its
// result waits until the held one is taken.
// reset clears all tables to unreachable at once, no clearing pass.
// registers: 0 self_id, 4 node_count, 8 neighbor_count; write only when idle.
module distance_vector_router
  import dvr_pkg::*;
#(
  parameter int NODES     = 16,
  parameter int NEIGHBORS = 8,
  parameter int INFINITE  = 999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // slot[2:0], source_node[6:3], target_node[10:7], cost[20:11]
  input  logic [1:0]  s_tuser,   // command
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // next_hop[3:0], route_found[4]
  output logic [0:0]  m_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NIW = $clog2(NODES);
  localparam int SIW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int NCW = $clog2(NODES + 1);
  localparam int NSW = $clog2(NEIGHBORS + 1);

  logic [3:0]     self_id;
  logic [4:0]     node_count;
  logic [3:0]     neighbor_count;
  logic [NCW-1:0] nc;
  logic [NSW-1:0] ns;
  reg_idx_t       widx;
  cmd_t           cmd;
  status_t        st;
  logic [NIW-1:0] d;
  logic [SIW-1:0] j;
  logic           m_status, m_found;
  logic [3:0]     m_next_hop;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id        <= '0;
      node_count     <= 5'd16;
      neighbor_count <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_SELF_ID:        self_id        <= pwdata[3:0];
        REG_NODE_COUNT:     node_count     <= pwdata[4:0];
        REG_NEIGHBOR_COUNT: neighbor_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SELF_ID:        prdata = {28'd0, self_id};
      REG_NODE_COUNT:     prdata = {27'd0, node_count};
      REG_NEIGHBOR_COUNT: prdata = {28'd0, neighbor_count};
      default:            prdata = '0;
    endcase
  end

  assign nc = (32'(node_count) > NODES) ? NCW'(NODES) : NCW'(node_count);
  assign ns = (32'(neighbor_count) > NEIGHBORS) ? NSW'(NEIGHBORS) : NSW'(neighbor_count);

  dvr_ctrl #(.NODES(NODES), .NEIGHBORS(NEIGHBORS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .nc       (nc),
    .ns       (ns),
    .st       (st),
    .cmd      (cmd),
    .d        (d),
    .j        (j)
  );

  dvr_datapath #(.NODES(NODES), .NEIGHBORS(NEIGHBORS), .INFINITE(INFINITE)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .s_command  (s_tuser),
    .s_slot     (s_tdata[2:0]),
    .s_source   (s_tdata[6:3]),
    .s_target   (s_tdata[10:7]),
    .s_cost     (s_tdata[20:11]),
    .s_last     (s_tlast),
    .self_id    (self_id),
    .nc         (nc),
    .ns         (ns),
    .cmd        (cmd),
    .d          (d),
    .j          (j),
    .st         (st),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_status   (m_status),
    .m_next_hop (m_next_hop),
    .m_found    (m_found)
  );

  assign m_tdata = {3'd0, m_found, m_next_hop};
  assign m_tuser = m_status;

endmodule

// ===== tb/testbench.sv =====
// testbench for distance_vector_router: directed table plus random traffic
// checked against a cycle-free behavioral predictor; depends on dvr_pkg
module testbench
  import dvr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 16;
  localparam int NEIGHBORS = 8;
  localparam int INF = 999;

  typedef struct packed {
    logic       status;
    logic [3:0] next_hop;
    logic       found;
  } route_res_t;

  typedef struct {
    op_t        op;
    logic [2:0] slot;
    logic [3:0] src;
    logic [3:0] dst;
    logic [9:0] cost;
    logic       last;
    logic       chk;
    route_res_t res;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, s_tlast = 0;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tready, m_tvalid, pready;
  logic [7:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  distance_vector_router dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [3:0] p_self;
  logic [4:0] p_nodes;
  logic [3:0] p_nbrs;
  int own_c[NODES];
  int nvec[NEIGHBORS][NODES];
  int nnode[NEIGHBORS];
  int lcost[NEIGHBORS];
  int hop[NODES];
  bit hvalid[NODES];

  route_res_t route_q[$];
  int errors = 0, accepted = 0, lookups_hit = 0, recomputes = 0;
  int send_idle = 0, recv_stall = 0, hold_cycles = 0;

  function automatic int nc_eff();
    return p_nodes < NODES ? p_nodes : NODES;
  endfunction
  function automatic int ns_eff();
    return p_nbrs < NEIGHBORS ? p_nbrs : NEIGHBORS;
  endfunction

  function automatic void route_reset();
    p_self = '0; p_nodes = 5'd16; p_nbrs = '0;
    for (int i = 0; i < NODES; i++) begin
      own_c[i] = INF; hop[i] = 0; hvalid[i] = 0;
    end
    for (int j = 0; j < NEIGHBORS; j++) begin
      nnode[j] = 0; lcost[j] = INF;
      for (int i = 0; i < NODES; i++) nvec[j][i] = INF;
    end
  endfunction

  function automatic void relax(bit use_skip, int skip, bit every_finite);
    int nc, ns, best, h, n, first, sum;
    bit imp;
    nc = nc_eff(); ns = ns_eff();
    for (int d = 0; d < nc; d++) begin
      best = own_c[d]; h = d; imp = 0;
      if (d != p_self && !(use_skip && d == skip)) begin
        for (int j = 0; j < ns; j++) begin
          n = nnode[j];
          first = n < nc ? own_c[n] : INF;
          sum = first + nvec[j][d];
          if (sum > INF) sum = INF;
          if (sum < best) begin
            best = sum; h = n; imp = 1;
          end
        end
      end
      own_c[d] = best;
      if (every_finite ? (best != INF) : imp) begin
        hop[d] = h; hvalid[d] = 1;
      end
    end
  endfunction

  function automatic route_res_t route_predict(row_t r);
    route_res_t o;
    int c, nc, ns, j;
    bit hit;
    o = '0;
    c = r.cost > INF ? INF : r.cost;
    nc = nc_eff(); ns = ns_eff();
    case (r.op)
      OP_SET_LINK: begin
        nnode[r.slot] = r.src; lcost[r.slot] = c;
      end
      OP_VECTOR: begin
        hit = 0;
        for (j = 0; j < ns; j++) if (nnode[j] == r.src) begin
          hit = 1; break;
        end
        if (!hit) o.status = 1;
        else begin
          if (r.dst < nc) nvec[j][r.dst] = c;
          if (r.last) begin
            relax(0, 0, 0); recomputes++;
          end
        end
      end
      OP_DISCONNECT: begin
        for (int k = 0; k < ns; k++) if (nnode[k] == r.src) lcost[k] = INF;
        for (int d = 0; d < nc; d++) own_c[d] = (d == p_self) ? 0 : INF;
        for (int d = 0; d < nc; d++)
          for (int k = 0; k < ns; k++) if (nnode[k] == d) own_c[d] = lcost[k];
        for (int d = 0; d < nc; d++) if (p_self == r.src || d == r.src) own_c[d] = INF;
        for (int k = 0; k < ns; k++)
          for (int d = 0; d < nc; d++)
            if (nnode[k] == r.src || d == r.src) nvec[k][d] = INF;
        hvalid[r.src] = 0;
        relax(1, r.src, 1); recomputes++;
      end
      default: begin
        if (hvalid[r.dst]) begin
          o.next_hop = 4'(hop[r.dst]); o.found = 1; lookups_hit++;
        end
      end
    endcase
    return o;
  endfunction

  // receiver side with checking
  int stall_pct = 0;
  bit hold_off = 0;
  always @(posedge clk) begin
    route_res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser[0]; got.next_hop = m_tdata[3:0]; got.found = m_tdata[4];
        if (route_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $realtime, got);
          errors++;
        end else begin
          want = route_q.pop_front();
          if (got !== want) begin
            $display("%0t: status exp %0d got %0d, next_hop exp %0d got %0d, found exp %0d got %0d",
                     $realtime, want.status, got.status, want.next_hop, got.next_hop,
                     want.found, got.found);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 0;
      end else
        m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(row_t r);
    route_res_t e;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= r.op; s_tlast <= r.last;
    s_tdata <= {3'b0, r.cost, r.dst, r.src, r.slot};
    do @(posedge clk); while (!s_tready);
    e = route_predict(r);
    if (r.chk && e !== r.res) begin
      $display("%0t: directed row exp %h, predictor %h", $realtime, r.res, e);
      errors++;
    end
    route_q.push_back(e);
    accepted++;
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    s_tvalid <= 0;
    wait (route_q.size() == 0);
    repeat (NODES * (NEIGHBORS + 4) + 20) @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk); penable <= 1;
    @(posedge clk); psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_SELF_ID: p_self = v[3:0];
      REG_NODE_COUNT: p_nodes = v[4:0];
      default: p_nbrs = v[3:0];
    endcase
  endtask

  function automatic row_t mk(op_t op, int slot, int src, int dst, int cost, bit last,
                              bit chk = 0, route_res_t res = '0);
    row_t r;
    r.op = op; r.slot = 3'(slot); r.src = 4'(src); r.dst = 4'(dst); r.cost = 10'(cost);
    r.last = last;
    r.chk = chk; r.res = res;
    return r;
  endfunction

  function automatic row_t rand_row(int nsl, int nn);
    row_t r;
    int k;
    k = $urandom_range(99);
    r.slot = 3'($urandom_range(7));
    r.src = 4'((k < 80 && nsl > 0) ? nnode[$urandom_range(nsl - 1)] : $urandom_range(15));
    r.dst = 4'($urandom_range(99) < 85 ? $urandom_range(nn - 1) : $urandom_range(15));
    r.cost = 10'($urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(60));
    r.last = $urandom_range(7) == 0;
    r.chk = 0;
    if (k < 10) r.op = OP_SET_LINK;
    else if (k < 70) r.op = OP_VECTOR;
    else if (k < 74) r.op = OP_DISCONNECT;
    else r.op = OP_LOOKUP;
    return r;
  endfunction

  row_t dir_rows[$];

  initial begin
    route_res_t none, ign, hit3;
    int nn;
    none = '0; ign = '0; ign.status = 1;
    hit3 = '0; hit3.found = 1; hit3.next_hop = 3;
    route_reset();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    reg_write(REG_SELF_ID, 0);
    reg_write(REG_NODE_COUNT, 16);
    reg_write(REG_NEIGHBOR_COUNT, 8);
    dir_rows = '{
      mk(OP_LOOKUP, 0, 0, 0, 0, 0, 1, none),
      mk(OP_LOOKUP, 0, 0, 15, 0, 0, 1, none),
      mk(OP_VECTOR, 0, 9, 2, 5, 1, 1, ign),
      mk(OP_SET_LINK, 0, 3, 0, 4, 0, 1, none),
      mk(OP_SET_LINK, 1, 5, 0, 1023, 0, 1, none),
      mk(OP_SET_LINK, 7, 15, 0, 0, 0, 1, none),
      mk(OP_DISCONNECT, 0, 12, 0, 0, 0, 1, none),
      mk(OP_LOOKUP, 0, 0, 3, 0, 0, 1, hit3),
      mk(OP_VECTOR, 0, 3, 6, 7, 0),
      mk(OP_VECTOR, 0, 3, 15, 0, 0),
      mk(OP_VECTOR, 0, 3, 1, 999, 1),
      mk(OP_LOOKUP, 0, 0, 6, 0, 0, 1, hit3),
      mk(OP_LOOKUP, 0, 0, 15, 0, 0),
      mk(OP_VECTOR, 0, 15, 6, 1, 1),
      mk(OP_LOOKUP, 0, 0, 6, 0, 0),
      mk(OP_VECTOR, 0, 5, 2, 1023, 1),
      mk(OP_DISCONNECT, 0, 3, 0, 0, 0),
      mk(OP_LOOKUP, 0, 0, 3, 0, 0),
      mk(OP_LOOKUP, 0, 0, 6, 0, 0),
      mk(OP_DISCONNECT, 0, 0, 0, 0, 0),
      mk(OP_SET_LINK, 2, 10, 0, 2, 1),
      mk(OP_VECTOR, 0, 10, 11, 3, 1)
    };
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 83; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 83; end
        default: begin send_idle = 19; stall_pct = 19; end
      endcase
      if (ph == 7) begin
        reg_write(REG_SELF_ID, 15);
        reg_write(REG_NODE_COUNT, 31);
        reg_write(REG_NEIGHBOR_COUNT, 15);
      end else if (ph > 0) begin
        reg_write(REG_SELF_ID, $urandom_range(15));
        reg_write(REG_NODE_COUNT, ph == 3 ? 1 : $urandom_range(2, 16));
        reg_write(REG_NEIGHBOR_COUNT, ph == 4 ? 0 : $urandom_range(8));
      end
      if (ph == 2) hold_cycles = 400;
      nn = nc_eff();
      for (int k = 0; k < 8; k++)
        send_request(mk(OP_SET_LINK, k, $urandom_range(15), 0, $urandom_range(20), 0));
      for (int i = 0; i < 142; i++) send_request(rand_row(ns_eff(), nn));
    end

    s_tvalid <= 0;
    wait (route_q.size() == 0);
    repeat (NODES * (NEIGHBORS + 4) + 20) @(posedge clk);
    $display("covered %0d requests, %0d recomputes, %0d lookups with a route",
             accepted, recomputes, lookups_hit);
    $display("register settings included extremes and all four idle/stall mixes");
    if (errors == 0 && route_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
